>>> rtl/stack_machine_executor_assert.svh
// assertion macros for the stack machine executor
// used by the top level only, no other dependencies
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// condition must hold on every clock edge out of reset
`define SME_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sme assertion failed");

// consequent in the same cycle
`define SME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sme assertion failed");

// consequent in the cycle after the antecedent
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sme assertion failed");

`endif

>>> rtl/sme_pkg.sv
// shared types and constants of the stack machine executor
// no dependencies
`timescale 1ns / 1ps

package sme_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_COPY  = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_REM   = 4'd7,
    OP_PRINT = 4'd8,
    OP_READ  = 4'd9,
    OP_HALT  = 4'd10
  } sme_op_e;

  typedef enum logic [2:0] {
    STATUS_OK     = 3'd0,
    STATUS_UNDER  = 3'd1,
    STATUS_OVER   = 3'd2,
    STATUS_DIVZ   = 3'd3,
    STATUS_HALTED = 3'd4
  } sme_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_FETCH,
    ST_DIV,
    ST_FINISH
  } sme_state_e;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [WORD_W-1:0] immediate;
    logic signed [WORD_W-1:0] read_value;
  } sme_in_t;

  typedef struct packed {
    logic                     print_valid;
    logic signed [WORD_W-1:0] print_value;
    logic [2:0]               status;
    logic                     halted;
  } sme_out_t;

  typedef struct packed {
    logic              start;
    logic              want_rem;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } sme_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } sme_div_rsp_t;

endpackage

>>> rtl/sme_chan_if.sv
// valid/ready channel carrying one item of a given payload type
// no dependencies
`timescale 1ns / 1ps

interface sme_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/sme_stack_mem.sv
// stack storage, one write port and one registered read port
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_stack_mem #(
  parameter int unsigned DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [IDX_W-1:0]               waddr_i,
  input  logic [sme_pkg::WORD_W-1:0]     wdata_i,
  input  logic [IDX_W-1:0]               raddr_i,
  output logic [sme_pkg::WORD_W-1:0]     rdata_o
);
  import sme_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sme_alu.sv
// add, subtract and multiply on the two top stack words
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_alu (
  input  sme_pkg::sme_op_e            op_i,
  input  logic [sme_pkg::WORD_W-1:0]  top_i,
  input  logic [sme_pkg::WORD_W-1:0]  nxt_i,
  output logic [sme_pkg::WORD_W-1:0]  res_o
);
  import sme_pkg::*;

  always_comb begin
    case (op_i)
      OP_ADD:  res_o = top_i + nxt_i;
      OP_SUB:  res_o = top_i - nxt_i;
      OP_MUL:  res_o = top_i * nxt_i;
      default: res_o = '0;
    endcase
  end

endmodule

>>> rtl/sme_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sme_pkg::sme_div_req_t req_i,
  output sme_pkg::sme_div_rsp_t rsp_o
);
  import sme_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] den_q, den_d;
  logic              nneg_q, nneg_d;
  logic              qneg_q, qneg_d;
  logic              want_rem_q, want_rem_d;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  assign rem_sh = {rem_q, quo_q[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    den_d      = den_q;
    nneg_d     = nneg_q;
    qneg_d     = qneg_q;
    want_rem_d = want_rem_q;
    if (req_i.start) begin
      busy_d     = 1'b1;
      cnt_d      = '0;
      rem_d      = '0;
      nneg_d     = req_i.num[WORD_W-1];
      qneg_d     = req_i.num[WORD_W-1] ^ req_i.den[WORD_W-1];
      want_rem_d = req_i.want_rem;
      quo_d      = req_i.num[WORD_W-1] ? (~req_i.num + WORD_W'(1)) : req_i.num;
      den_d      = req_i.den[WORD_W-1] ? (~req_i.den + WORD_W'(1)) : req_i.den;
    end else if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_d = diff[WORD_W-1:0];
      end else begin
        rem_d = rem_sh[WORD_W-1:0];
      end
      quo_d = {quo_q[WORD_W-2:0], ~diff[WORD_W]};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    den_q      <= den_d;
    nneg_q     <= nneg_d;
    qneg_q     <= qneg_d;
    want_rem_q <= want_rem_d;
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    if (want_rem_q) begin
      rsp_o.result = nneg_q ? (~rem_q + WORD_W'(1)) : rem_q;
    end else begin
      rsp_o.result = qneg_q ? (~quo_q + WORD_W'(1)) : quo_q;
    end
  end

endmodule

>>> rtl/stack_machine_executor.sv
// top level of the stack machine executor: sequencer, top-of-stack cache,
// output register; uses sme_pkg, sme_chan_if, sme_stack_mem, sme_alu, sme_divider
//
// in_i carries one instruction per item (opcode, immediate, read_value); out_o
// carries exactly one result item per instruction (print_valid, print_value,
// status, halted). Both are valid/ready channels; an item moves on a rising
// edge with valid and ready high.
// One instruction at a time: in_i.ready is high only while the sequencer idles.
// Steps between acceptance and the finish state that offers the result on out_o:
//   push, read, copy, halt, errors, unknown ops, pop/print emptying the stack: none
//   pop and print leaving entries behind: a stack read refills the cached top
//   add, sub, mul: read of the next word, then the shared alu
//   div, rem: read of the next word, then the 32 single-bit divider steps
// A new instruction is taken the cycle after the result is registered.
// While out_o is stalled a finished result waits in the output register; a
// following result holds in the sequencer until the register frees up.
// Reset empties the stack and clears the halt flag; memory contents are left
// as they are and never read before being written.
`timescale 1ns / 1ps

module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sme_chan_if.sink   in_i,
  sme_chan_if.source out_o
);
  import sme_pkg::*;

  `include "stack_machine_executor_assert.svh"

  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  sme_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              halt_q, halt_d;
  logic [WORD_W-1:0] top_q, top_d;
  sme_op_e           op_q, op_d;
  sme_status_e       st_q, st_d;
  logic              pv_q, pv_d;
  logic [WORD_W-1:0] pval_q, pval_d;
  logic              out_valid_q, out_valid_d;
  sme_out_t          out_pl_q;
  logic              out_load;

  logic              in_fire;
  sme_op_e           in_op;
  logic [WORD_W-1:0] in_val;
  logic              empty;
  logic              lt2;
  logic              full;
  logic              in_arith;
  logic              in_divop;
  logic              q_divop;
  logic              out_free;
  logic [CNT_W-1:0]  cm2;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] alu_res;
  sme_div_req_t      div_req;
  sme_div_rsp_t      div_rsp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_op      = sme_op_e'(in_i.payload.opcode);
  assign in_val     = (in_op == OP_READ) ? in_i.payload.read_value : in_i.payload.immediate;
  assign empty      = (count_q == '0);
  assign lt2        = (count_q < CNT_W'(2));
  assign full       = (count_q == CNT_W'(STACK_DEPTH));
  assign in_arith   = (in_op == OP_ADD) || (in_op == OP_SUB) || (in_op == OP_MUL) ||
                      (in_op == OP_DIV) || (in_op == OP_REM);
  assign in_divop   = (in_op == OP_DIV) || (in_op == OP_REM);
  assign q_divop    = (op_q == OP_DIV) || (op_q == OP_REM);
  assign out_free   = !out_valid_q || out_o.ready;
  assign cm2        = count_q - CNT_W'(2);

  sme_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cm2[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  sme_alu u_alu (
    .op_i  (op_q),
    .top_i (top_q),
    .nxt_i (mem_rdata),
    .res_o (alu_res)
  );

  always_comb begin
    div_req.start    = (state_q == ST_FETCH) && q_divop;
    div_req.want_rem = (op_q == OP_REM);
    div_req.num      = mem_rdata;
    div_req.den      = top_q;
  end

  sme_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_FINISH;
          if (!halt_q) begin
            if ((in_op == OP_POP || in_op == OP_PRINT) && !lt2) begin
              state_d = ST_RELOAD;
            end else if (in_arith && !lt2 && !(in_divop && top_q == '0)) begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_RELOAD: state_d = ST_FINISH;
      ST_FETCH: begin
        state_d = q_divop ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and stack control
  always_comb begin
    count_d   = count_q;
    halt_d    = halt_q;
    top_d     = top_q;
    op_d      = op_q;
    st_d      = st_q;
    pv_d      = pv_q;
    pval_d    = pval_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = in_val;
    out_load  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d   = in_op;
          st_d   = STATUS_OK;
          pv_d   = 1'b0;
          pval_d = '0;
          if (halt_q) begin
            st_d = STATUS_HALTED;
          end else begin
            case (in_op)
              OP_PUSH, OP_READ: begin
                if (full) begin
                  st_d = STATUS_OVER;
                end else begin
                  mem_we  = 1'b1;
                  top_d   = in_val;
                  count_d = count_q + CNT_W'(1);
                end
              end
              OP_POP, OP_PRINT: begin
                if (empty) begin
                  st_d = STATUS_UNDER;
                end else begin
                  count_d = count_q - CNT_W'(1);
                  if (in_op == OP_PRINT) begin
                    pv_d   = 1'b1;
                    pval_d = top_q;
                  end
                end
              end
              OP_COPY: begin
                if (empty) begin
                  st_d = STATUS_UNDER;
                end else if (full) begin
                  st_d = STATUS_OVER;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = top_q;
                  count_d   = count_q + CNT_W'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
                if (lt2) begin
                  st_d = STATUS_UNDER;
                end else if (in_divop && top_q == '0) begin
                  st_d = STATUS_DIVZ;
                end
              end
              OP_HALT: halt_d = 1'b1;
              default: ;
            endcase
          end
        end
      end
      ST_RELOAD: top_d = mem_rdata;
      ST_FETCH: begin
        if (!q_divop) begin
          mem_we    = 1'b1;
          mem_waddr = cm2[IDX_W-1:0];
          mem_wdata = alu_res;
          top_d     = alu_res;
          count_d   = count_q - CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cm2[IDX_W-1:0];
          mem_wdata = div_rsp.result;
          top_d     = div_rsp.result;
          count_d   = count_q - CNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    op_q   <= op_d;
    st_q   <= st_d;
    pv_q   <= pv_d;
    pval_q <= pval_d;
    if (out_load) begin
      out_pl_q.print_valid <= pv_q;
      out_pl_q.print_value <= pval_q;
      out_pl_q.status      <= st_q;
      out_pl_q.halted      <= halt_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_pl_q;

  `SME_ASSERT_HOLDS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(STACK_DEPTH))
  `SME_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halt_q, halt_q)
  `SME_ASSERT_NEXT(a_halted_frozen, clk_i, rst_ni, in_fire && halt_q, count_q == $past(count_q))
  `SME_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_rsp.done, state_q == ST_DIV)

endmodule
